// ===== rtl/bmcc_pkg.sv =====
package bmcc_pkg;

    localparam int GAP_W     = 12;
    localparam int COIN_W    = 12;
    localparam int DIFF_W    = GAP_W + 1;
    localparam int NUM_COINS = 7;
    localparam int NUM_REGS  = 7;
    localparam int MAX_GAP   = 4095;
    localparam int TABLE_D   = MAX_GAP + 1;
    localparam int ADDR_W    = $clog2(TABLE_D);
    localparam int PHASE_W   = $clog2(NUM_COINS + 1);
    localparam int REG_IDX_W = $clog2(NUM_REGS + 1);
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int QUEUE_D   = 2;

    typedef logic [NUM_COINS-1:0][COIN_W-1:0] coin_arr_t;

    localparam coin_arr_t COIN_RESET = {
        12'd100, 12'd50, 12'd20, 12'd10, 12'd5, 12'd2, 12'd1
    };

    typedef struct packed {
        logic [GAP_W-1:0] weight;
        logic             first_item;
        logic             last_item;
    } in_item_t;

    typedef struct packed {
        logic [GAP_W-1:0] min_coins;
        logic [GAP_W-1:0] pan_gap;
    } out_item_t;

    // one pending coin computation
    typedef struct packed {
        logic             valid;
        logic [GAP_W-1:0] gap;
    } job_t;

endpackage

// ===== rtl/bmcc_front.sv =====
module bmcc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bmcc_pkg::in_item_t s_data,
    input  logic              q_full,
    output bmcc_pkg::job_t    push
);
    import bmcc_pkg::*;

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] base;
    logic        [DIFF_W-1:0] mag;
    logic        [DIFF_W-1:0] wext;
    logic                     accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign wext    = {1'b0, s_data.weight};

    always_comb begin
        base = s_data.first_item ? '0 : diff_reg;
        if (base <= 0) begin
            diff_next = base + $signed(wext);
        end else begin
            diff_next = base - $signed(wext);
        end
        mag = diff_next[DIFF_W-1] ? DIFF_W'(-diff_next) : DIFF_W'(diff_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_reg <= '0;
        end else if (accept) begin
            diff_reg <= diff_next;
        end
    end

    always_comb begin
        push.valid = accept && s_data.last_item;
        // saturate the gap to the table size
        if (mag > DIFF_W'(MAX_GAP)) begin
            push.gap = GAP_W'(MAX_GAP);
        end else begin
            push.gap = mag[GAP_W-1:0];
        end
    end

endmodule

// ===== rtl/bmcc_queue.sv =====
module bmcc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  bmcc_pkg::job_t push,
    output logic           full,
    input  logic           pop,
    output bmcc_pkg::job_t head
);
    import bmcc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_D);
    localparam int CNT_W = $clog2(QUEUE_D + 1);

    logic [GAP_W-1:0] slot_reg [QUEUE_D];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == CNT_W'(QUEUE_D);
    assign head.valid = count_reg != '0;
    assign head.gap   = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.gap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_D - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_D - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

// ===== rtl/bmcc_back.sv =====
module bmcc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  bmcc_pkg::coin_arr_t coins,
    input  bmcc_pkg::job_t      head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output bmcc_pkg::out_item_t m_data
);
    import bmcc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(NUM_COINS);

    logic [GAP_W-1:0]  mem [TABLE_D];
    logic [GAP_W-1:0]  rdata_reg;

    logic [1:0]         state_reg;
    logic [GAP_W-1:0]   gap_reg;
    logic [GAP_W-1:0]   amt_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [GAP_W-1:0]   best_reg;
    logic [GAP_W-1:0]   result_reg;
    logic               rd_ok_reg;
    logic               rd_zero_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [COIN_W-1:0]  coin_sel;
    logic               coin_ok;
    logic [ADDR_W-1:0]  rd_addr;
    logic [GAP_W:0]     cand;
    logic [GAP_W-1:0]   best_eff;
    logic               out_free;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == ST_IDLE) && head.valid;

    // issue one table read per coin; the last phase writes the entry
    always_comb begin
        coin_sel = (phase_reg < LAST_PHASE) ? coins[phase_reg[PHASE_W-1:0]] : '0;
        coin_ok  = (phase_reg != LAST_PHASE) && (coin_sel != '0) && (coin_sel <= amt_reg);
        rd_addr  = ADDR_W'(amt_reg - coin_sel);
        cand     = (rd_zero_reg ? '0 : {1'b0, rdata_reg}) + 1'b1;
        if (rd_ok_reg && (cand < {1'b0, best_reg})) begin
            best_eff = cand[GAP_W-1:0];
        end else begin
            best_eff = best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if ((state_reg == ST_RUN) && (phase_reg == LAST_PHASE)) begin
            mem[ADDR_W'(amt_reg)] <= best_eff;
        end
    end

    always_ff @(posedge aclk) begin
        rd_zero_reg <= rd_addr == '0;
        if (state_reg == ST_IDLE) begin
            gap_reg   <= head.gap;
            amt_reg   <= GAP_W'(1);
            best_reg  <= GAP_W'(1);
            phase_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            if (phase_reg == LAST_PHASE) begin
                result_reg <= best_eff;
                amt_reg    <= amt_reg + 1'b1;
                best_reg   <= amt_reg + 1'b1;
                phase_reg  <= '0;
            end else begin
                best_reg  <= best_eff;
                phase_reg <= phase_reg + 1'b1;
            end
        end
        if ((state_reg == ST_IDLE) && head.valid && (head.gap == '0)) begin
            result_reg <= '0;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg.min_coins <= result_reg;
            m_data_reg.pan_gap   <= gap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_ok_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_ok_reg <= (state_reg == ST_RUN) && coin_ok;
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (head.valid) begin
                        state_reg <= (head.gap == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if ((phase_reg == LAST_PHASE) && (amt_reg == gap_reg)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/balance_then_min_coin_change_unit.sv =====
// Weights are taken one per cycle while the job queue is not full; a weight that does
// not end a run gives no result. A run's last weight queues a job (two-deep queue); the
// coin walk then fills the count table for each amount from 1 up to the gap, one coin per
// cycle on the table's single read port, then writes the amount's entry.
// Synchronous active-low reset clears the pan difference, queue, walk and output;
// coins return to 1, 2, 5, 10, 20, 50, 100. The count table needs no clearing.
module balance_then_min_coin_change_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  bmcc_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output bmcc_pkg::out_item_t                   m_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bmcc_pkg::PADDR_W-1:0]          paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import bmcc_pkg::*;

    coin_arr_t             coin_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  q_full;
    logic                  pop;
    job_t                  push;
    job_t                  head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coin_reg <= COIN_RESET;
        end else if (psel && penable && pwrite && (reg_idx < REG_IDX_W'(NUM_REGS))) begin
            coin_reg[reg_idx] <= pwdata[COIN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx < REG_IDX_W'(NUM_REGS)) begin
            prdata = {{(32 - COIN_W){1'b0}}, coin_reg[reg_idx]};
        end
    end

    bmcc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push)
    );

    bmcc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .pop     (pop),
        .head    (head)
    );

    bmcc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coins   (coin_reg),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== tb/coin_change_checker.sv =====
`timescale 1ns / 1ps

module coin_change_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  bmcc_pkg::in_item_t           s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  bmcc_pkg::out_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmcc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           pending,
    output int                           results_checked
);

    logic [bmcc_pkg::COIN_W-1:0] coin_value [bmcc_pkg::NUM_REGS];
    int                          pan_balance;
    bmcc_pkg::out_item_t         expected_change_q [$];
    bmcc_pkg::out_item_t         want;
    int                          gap;
    int                          reg_idx;
    int                          mismatches = 0;
    int                          checked    = 0;

    // least coin count for gap, filling every amount from one upwards
    function automatic logic [bmcc_pkg::GAP_W-1:0] fewest_coins(input int target);
        logic [bmcc_pkg::GAP_W-1:0] fewest [0:bmcc_pkg::MAX_GAP];
        int                         best;
        int                         coin;
        int                         amount;
        int                         k;
        fewest[0] = '0;
        for (amount = 1; amount <= target; amount++) begin
            best = amount;
            for (k = 0; k < bmcc_pkg::NUM_REGS && k < bmcc_pkg::NUM_COINS; k++) begin
                coin = coin_value[k];
                // skip a zero coin and any coin above the amount
                if (coin != 0 && coin <= amount && int'(fewest[amount - coin]) + 1 < best) begin
                    best = int'(fewest[amount - coin]) + 1;
                end
            end
            fewest[amount] = best[bmcc_pkg::GAP_W-1:0];
        end
        return fewest[target];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pan_balance = 0;
            coin_value[0] = 12'd1;
            coin_value[1] = 12'd2;
            coin_value[2] = 12'd5;
            coin_value[3] = 12'd10;
            coin_value[4] = 12'd20;
            coin_value[5] = 12'd50;
            coin_value[6] = 12'd100;
            expected_change_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.first_item) begin
                    pan_balance = 0;
                end
                // a tie goes to the first pan
                if (pan_balance <= 0) begin
                    pan_balance += int'(s_data.weight);
                end else begin
                    pan_balance -= int'(s_data.weight);
                end
                if (s_data.last_item) begin
                    gap = (pan_balance < 0) ? -pan_balance : pan_balance;
                    if (gap > bmcc_pkg::MAX_GAP) begin
                        gap = bmcc_pkg::MAX_GAP;
                    end
                    want.pan_gap   = gap[bmcc_pkg::GAP_W-1:0];
                    want.min_coins = fewest_coins(gap);
                    expected_change_q.push_back(want);
                end
            end

            if (m_valid && m_ready) begin
                checked++;
                if (expected_change_q.size() == 0) begin
                    $error("result with no request waiting: min_coins %0d, pan_gap %0d",
                           m_data.min_coins, m_data.pan_gap);
                    mismatches++;
                end else begin
                    want = expected_change_q.pop_front();
                    if (m_data.min_coins !== want.min_coins) begin
                        $error("min_coins: expected %0d, got %0d",
                               want.min_coins, m_data.min_coins);
                        mismatches++;
                    end
                    if (m_data.pan_gap !== want.pan_gap) begin
                        $error("pan_gap: expected %0d, got %0d", want.pan_gap, m_data.pan_gap);
                        mismatches++;
                    end
                end
            end

            if (psel && penable && pready) begin
                reg_idx = int'(paddr) >> 2;
                if (reg_idx < bmcc_pkg::NUM_REGS) begin
                    if (pwrite) begin
                        coin_value[reg_idx] = pwdata[bmcc_pkg::COIN_W-1:0];
                    end else if (prdata[bmcc_pkg::COIN_W-1:0] !== coin_value[reg_idx]) begin
                        $error("coin_%0d: expected %0d, got %0d", reg_idx,
                               coin_value[reg_idx], prdata[bmcc_pkg::COIN_W-1:0]);
                        mismatches++;
                    end
                end
            end
        end
        fail_count      <= mismatches;
        pending         <= expected_change_q.size();
        results_checked <= checked;
    end

endmodule

// ===== tb/tb_balance_then_min_coin_change_unit.sv =====
`timescale 1ns / 1ps

module tb_balance_then_min_coin_change_unit;

    localparam int RUN_ITEMS   = 1350;
    localparam int PHASES      = 5;
    localparam int HOLD_CYCLES = 800;
    localparam int SETTLE      = 16;
    localparam int ADDR_BITS   = bmcc_pkg::PADDR_W;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    bmcc_pkg::in_item_t          s_data;
    logic                        m_valid;
    logic                        m_ready;
    bmcc_pkg::out_item_t         m_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_BITS-1:0]        paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        hold_req;

    int                          fail_count;
    int                          pending;
    int                          results_checked;
    int                          weights_sent  = 0;
    int                          settings_used = 0;
    bit                          sender_quiet  = 1'b0;
    logic [bmcc_pkg::COIN_W-1:0] coin_plan [bmcc_pkg::NUM_REGS];

    always #10 aclk = ~aclk;

    balance_then_min_coin_change_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    coin_change_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    function automatic logic [bmcc_pkg::COIN_W-1:0] standard_coin(input int idx);
        case (idx)
            0:       return 12'd1;
            1:       return 12'd2;
            2:       return 12'd5;
            3:       return 12'd10;
            4:       return 12'd20;
            5:       return 12'd50;
            default: return 12'd100;
        endcase
    endfunction

    task automatic send_weight(input logic [bmcc_pkg::GAP_W-1:0] w, input logic open_run,
                               input logic close_run);
        int unsigned pause;
        pause = sender_quiet ? 0 : $urandom_range(0, 19);
        if (pause > 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_data  <= '{weight: w, first_item: open_run, last_item: close_run};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        weights_sent++;
    endtask

    // wait for every result, then let the block settle before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic load_coins(input bit do_write);
        int i;
        if (do_write) begin
            for (i = 0; i < bmcc_pkg::NUM_REGS; i++) begin
                psel    <= 1'b1;
                penable <= 1'b0;
                pwrite  <= 1'b1;
                paddr   <= ADDR_BITS'(4 * i);
                pwdata  <= {20'd0, coin_plan[i]};
                @(posedge aclk);
                penable <= 1'b1;
                @(posedge aclk);
            end
            settings_used++;
        end
        // read back every register
        for (i = 0; i < bmcc_pkg::NUM_REGS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= ADDR_BITS'(4 * i);
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : result_sink
        int unsigned stall;
        int unsigned quiet_left;
        bit          hold_taken;
        stall      = 0;
        quiet_left = 0;
        hold_taken = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (quiet_left > 0) begin
                    stall = 0;
                    quiet_left--;
                end else if ($urandom_range(0, 9) == 0) begin
                    quiet_left = 20;
                    stall      = 0;
                end else begin
                    stall = $urandom_range(0, 19);
                end
            end
            // hold off once for long enough that the job queue fills
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall      = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : run_limit
        repeat (40) #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int phase_goal;
        int directed_total;
        int run_len;
        int pick;
        int heavy;
        int partner;
        int k;
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_data   <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        hold_req <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values of the coin registers
        load_coins(1'b0);

        // standard coins: zero gap, largest gap, tie to first pan, kept difference
        send_weight(12'd0, 1'b1, 1'b1);
        send_weight(12'd4095, 1'b1, 1'b1);
        send_weight(12'd7, 1'b1, 1'b0);
        send_weight(12'd7, 1'b0, 1'b0);
        send_weight(12'd3, 1'b0, 1'b0);
        send_weight(12'd10, 1'b0, 1'b1);
        send_weight(12'd1, 1'b0, 1'b1);
        send_weight(12'd2730, 1'b1, 1'b0);
        send_weight(12'd1365, 1'b0, 1'b1);
        drain();

        // no unit coin, two zero coins
        coin_plan[0] = 12'd3;
        coin_plan[1] = 12'd0;
        coin_plan[2] = 12'd7;
        coin_plan[3] = 12'd0;
        coin_plan[4] = 12'd11;
        coin_plan[5] = 12'd4095;
        coin_plan[6] = 12'd25;
        load_coins(1'b1);
        send_weight(12'd1, 1'b1, 1'b1);
        send_weight(12'd2, 1'b1, 1'b1);
        send_weight(12'd4, 1'b1, 1'b1);
        send_weight(12'd6, 1'b1, 1'b1);
        send_weight(12'd14, 1'b1, 1'b1);
        drain();

        for (k = 0; k < bmcc_pkg::NUM_REGS; k++) coin_plan[k] = 12'd4095;
        load_coins(1'b1);
        send_weight(12'd4095, 1'b1, 1'b1);
        send_weight(12'd4094, 1'b1, 1'b1);
        drain();

        for (k = 0; k < bmcc_pkg::NUM_REGS; k++) coin_plan[k] = 12'd1;
        load_coins(1'b1);
        send_weight(12'd4095, 1'b1, 1'b1);
        drain();

        // back-pressure: keep offering requests while the results are held off
        for (k = 0; k < bmcc_pkg::NUM_REGS; k++) coin_plan[k] = standard_coin(k);
        load_coins(1'b1);
        sender_quiet = 1'b1;
        hold_req <= 1'b1;
        for (k = 0; k < 16; k++) send_weight(12'($urandom_range(1, 40)), 1'b1, 1'b1);
        drain();
        sender_quiet = 1'b0;

        directed_total = weights_sent;
        for (phase = 0; phase < PHASES; phase++) begin
            for (k = 0; k < bmcc_pkg::NUM_REGS; k++) begin
                case (phase)
                    0: coin_plan[k] = standard_coin(k);
                    1: coin_plan[k] = (k == 0) ? 12'd1 : 12'($urandom_range(2, 60));
                    2: begin
                        if (k == 0) begin
                            coin_plan[k] = 12'($urandom_range(2, 9));
                        end else begin
                            coin_plan[k] = ($urandom_range(0, 2) == 0) ? 12'd0
                                         : 12'($urandom_range(1, 40));
                        end
                    end
                    3: coin_plan[k] = (k == 0) ? 12'd1 : (k == 3) ? 12'd2 : 12'd4095;
                    default: begin
                        coin_plan[k] = ($urandom_range(0, 3) == 0)
                                     ? 12'($urandom_range(0, 4095))
                                     : 12'($urandom_range(1, 30));
                    end
                endcase
            end
            load_coins(1'b1);

            phase_goal = directed_total + (phase + 1) * RUN_ITEMS / PHASES;
            while (weights_sent < phase_goal) begin
                sender_quiet = ($urandom_range(0, 4) == 0);
                pick         = $urandom_range(0, 99);
                run_len      = $urandom_range(1, 8);
                if (pick < 60) begin
                    // light run, small gap
                    for (k = 0; k < run_len; k++) begin
                        send_weight(12'($urandom_range(0, 63)), k == 0, k == run_len - 1);
                    end
                end else if (pick < 85) begin
                    // heavy matched pair, then a light tail
                    heavy   = $urandom_range(0, 4095);
                    partner = heavy + $urandom_range(0, 63) - 31;
                    if (partner < 0) partner = 0;
                    if (partner > 4095) partner = 4095;
                    send_weight(12'(heavy), 1'b1, 1'b0);
                    send_weight(12'(partner), 1'b0, run_len == 1);
                    for (k = 1; k < run_len; k++) begin
                        send_weight(12'($urandom_range(0, 63)), 1'b0, k == run_len - 1);
                    end
                end else if (pick < 99) begin
                    // broken runs: starts and ends anywhere
                    for (k = 0; k < run_len; k++) begin
                        send_weight(12'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                                    $urandom_range(0, 2) == 0);
                    end
                end else begin
                    send_weight(12'($urandom_range(0, 4095)), 1'b1, 1'b0);
                    send_weight(12'($urandom_range(0, 4095)), 1'b0, 1'b1);
                end
            end
            sender_quiet = 1'b0;
            drain();
        end

        $display("Run covered %0d weights and %0d coin results over %0d coin settings,",
                 weights_sent, results_checked, settings_used);
        $display("with zero and missing unit coins and one long result hold-off.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== balance_then_min_coin_change_unit.f =====
rtl/bmcc_pkg.sv
rtl/bmcc_front.sv
rtl/bmcc_queue.sv
rtl/bmcc_back.sv
rtl/balance_then_min_coin_change_unit.sv
tb/coin_change_checker.sv
tb/tb_balance_then_min_coin_change_unit.sv
